[rtl/core/bcdc_pkg.sv]
// ----------------------------------------------------------------------------
// bcdc_pkg
// Shared types, register indexes and constants of the bit-crush, downsample
// and clip block.
// ----------------------------------------------------------------------------
package bcdc_pkg;

	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 32;

	typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

	localparam cfg_idx_t REG_DISTORTION_ON = 3'd0;
	localparam cfg_idx_t REG_CRUSH_BITS    = 3'd1;
	localparam cfg_idx_t REG_RATE_CODE     = 3'd2;
	localparam cfg_idx_t REG_OUT_GAIN      = 3'd3;
	localparam cfg_idx_t REG_CLIP_LEVEL    = 3'd4;

	localparam int GAIN_W  = 32;
	localparam int CLIP_W  = 15;
	localparam int CRUSH_W = 3;
	localparam int RATE_W  = 3;
	localparam int OUT_W   = 16;
	localparam int FILL_W  = 5;
	localparam int SUM_W   = 62;
	localparam int DIV_W   = 45;
	localparam int CHUNK_W = 16;

	localparam logic [GAIN_W-1:0] GAIN_RESET = 32'd65536;
	localparam logic [CLIP_W-1:0] CLIP_RESET = 15'd32700;
	localparam logic [SUM_W-1:0]  SUM_LIM    = {1'b0, {(SUM_W-1){1'b1}}};

	function automatic logic [FILL_W-1:0] win_len(input logic [RATE_W-1:0] code);
		logic [FILL_W-1:0] len;
		case (code)
			3'd0: len = 5'd1;
			3'd1: len = 5'd2;
			3'd2: len = 5'd3;
			3'd3: len = 5'd4;
			3'd4: len = 5'd8;
			3'd5: len = 5'd10;
			3'd6: len = 5'd20;
			default: len = 5'd1;
		endcase
		return len;
	endfunction

endpackage

[rtl/core/bcdc_in_if.sv]
// ----------------------------------------------------------------------------
// bcdc_in_if
// Input sample channel: valid, ready and one signed Q24.8 sample.
// ----------------------------------------------------------------------------
interface bcdc_in_if #(
	parameter int SAMPLE_BITS = 32
) ();
	logic                          valid;
	logic                          ready;
	logic signed [SAMPLE_BITS-1:0] mix_sample;

	modport source (output valid, output mix_sample, input ready);
	modport sink (input valid, input mix_sample, output ready);
endinterface

[rtl/core/bcdc_out_if.sv]
// ----------------------------------------------------------------------------
// bcdc_out_if
// Output sample channel: valid, ready, one clipped sample and a run marker.
// ----------------------------------------------------------------------------
interface bcdc_out_if ();
	logic                              valid;
	logic                              ready;
	logic signed [bcdc_pkg::OUT_W-1:0] out_sample;
	logic                              last_of_run;

	modport source (output valid, output out_sample, output last_of_run, input ready);
	modport sink (input valid, input out_sample, input last_of_run, output ready);
endinterface

[rtl/core/bit_crush_downsample_clip.sv]
// ----------------------------------------------------------------------------
// bit_crush_downsample_clip
// Gain, bit reduction, window averaging and clipping of a mixed sample stream.
// ----------------------------------------------------------------------------
//
// Channel     Direction  Payload                      Transfer when
// samp_in     sink       mix_sample                   valid && ready
// samp_out    source     out_sample, last_of_run      valid && ready
// cfg         write      cfg_index, cfg_wdata         cfg_we
//
// The gain is applied by one 16 x 32 multiplier, one slice per cycle, over NCH
// slices, where NCH is the number of 16-bit slices of SAMPLE_BITS (2 at the
// default). A closing window then passes through the one-bit-a-cycle divider.
// Each result waits in the output register until its transfer; the input is
// not ready until the last result of the sample has gone out.
// Reset clears the window and loads the register defaults.
// ----------------------------------------------------------------------------
module bit_crush_downsample_clip #(
	parameter int SAMPLE_BITS = 32
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_we,
	input  logic [bcdc_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [bcdc_pkg::CFG_DATA_W-1:0]    cfg_wdata,
	bcdc_in_if.sink                            samp_in,
	bcdc_out_if.source                         samp_out
);

	localparam int NCH   = (SAMPLE_BITS + bcdc_pkg::CHUNK_W - 1) / bcdc_pkg::CHUNK_W;
	localparam int OP_W  = NCH * bcdc_pkg::CHUNK_W;
	localparam int ACC_W = OP_W + bcdc_pkg::GAIN_W;
	localparam int EXT_W = (ACC_W > bcdc_pkg::SUM_W) ? ACC_W : bcdc_pkg::SUM_W;
	localparam int MC_W  = (NCH > 1) ? $clog2(NCH) : 1;
	localparam int PP_W  = bcdc_pkg::CHUNK_W + bcdc_pkg::GAIN_W;
	localparam int DC_W  = $clog2(bcdc_pkg::DIV_W);
	localparam int SH_W  = 5;

	typedef enum logic [2:0] {
		S_IDLE,
		S_MUL,
		S_ACC,
		S_DIV,
		S_EMIT
	} state_t;

	state_t                                 state_q;
	logic                                   dist_q;
	logic [bcdc_pkg::CRUSH_W-1:0]           crush_q;
	logic [bcdc_pkg::RATE_W-1:0]            rate_q;
	logic [bcdc_pkg::GAIN_W-1:0]            gain_q;
	logic [bcdc_pkg::CLIP_W-1:0]            clip_q;
	logic signed [bcdc_pkg::SUM_W-1:0]      sum_q;
	logic [bcdc_pkg::FILL_W-1:0]            fill_q;
	logic [OP_W-1:0]                        op_q;
	logic [ACC_W-1:0]                       acc_q;
	logic [MC_W-1:0]                        mcnt_q;
	logic                                   neg_q;
	logic [bcdc_pkg::DIV_W-1:0]             div_q;
	logic [bcdc_pkg::FILL_W-1:0]            rem_q;
	logic [bcdc_pkg::FILL_W-1:0]            dvs_q;
	logic [DC_W-1:0]                        dcnt_q;
	logic [bcdc_pkg::FILL_W-1:0]            left_q;
	logic                                   out_valid_q;
	logic signed [bcdc_pkg::OUT_W-1:0]      out_sample_q;
	logic                                   out_last_q;

	logic                                   in_xfer;
	logic                                   out_xfer;
	logic                                   in_neg;
	logic [SAMPLE_BITS-1:0]                 in_mag;
	logic [SH_W-1:0]                        crush_sh;
	logic [SAMPLE_BITS-1:0]                 in_crushed;
	logic [PP_W-1:0]                        pp;
	logic [EXT_W-1:0]                       acc_ext;
	logic [bcdc_pkg::SUM_W-2:0]             prod_sat;
	logic signed [bcdc_pkg::SUM_W:0]        term;
	logic signed [bcdc_pkg::SUM_W:0]        sum_raw;
	logic signed [bcdc_pkg::SUM_W-1:0]      sum_sat;
	logic [bcdc_pkg::SUM_W-1:0]             sum_mag;
	logic [bcdc_pkg::FILL_W-1:0]            fill_nxt;
	logic                                   win_close;
	logic [bcdc_pkg::CLIP_W-1:0]            gain_q15;
	logic [bcdc_pkg::CLIP_W-1:0]            gain_mag;
	logic [bcdc_pkg::FILL_W:0]              trial;
	logic                                   trial_ge;
	logic [bcdc_pkg::CLIP_W-1:0]            avg_mag;
	logic [bcdc_pkg::OUT_W-1:0]             gain_out;
	logic [bcdc_pkg::OUT_W-1:0]             avg_out;

	assign in_xfer  = samp_in.valid && samp_in.ready;
	assign out_xfer = out_valid_q && samp_out.ready;

	assign samp_in.ready        = (state_q == S_IDLE);
	assign samp_out.valid       = out_valid_q;
	assign samp_out.out_sample  = out_sample_q;
	assign samp_out.last_of_run = out_last_q;

	always_comb begin
		in_neg     = samp_in.mix_sample[SAMPLE_BITS-1];
		in_mag     = in_neg ? (~samp_in.mix_sample + 1'b1) : samp_in.mix_sample;
		crush_sh   = SH_W'(8) + {1'b0, crush_q, 1'b0};
		in_crushed = in_mag >> crush_sh;

		pp = op_q[OP_W-1 -: bcdc_pkg::CHUNK_W] * gain_q;

		acc_ext  = EXT_W'(acc_q);
		prod_sat = (|acc_ext[EXT_W-1:bcdc_pkg::SUM_W-1]) ? bcdc_pkg::SUM_LIM[bcdc_pkg::SUM_W-2:0]
		                                                 : acc_ext[bcdc_pkg::SUM_W-2:0];
		term     = neg_q ? -$signed({2'b00, prod_sat}) : $signed({2'b00, prod_sat});
		sum_raw  = $signed({sum_q[bcdc_pkg::SUM_W-1], sum_q}) + term;
		if (sum_raw > $signed({1'b0, bcdc_pkg::SUM_LIM})) begin
			sum_sat = $signed(bcdc_pkg::SUM_LIM);
		end else if (sum_raw < -$signed({1'b0, bcdc_pkg::SUM_LIM})) begin
			sum_sat = -$signed(bcdc_pkg::SUM_LIM);
		end else begin
			sum_sat = sum_raw[bcdc_pkg::SUM_W-1:0];
		end
		sum_mag = sum_sat[bcdc_pkg::SUM_W-1] ? (~sum_sat + 1'b1) : sum_sat;

		fill_nxt  = fill_q + 1'b1;
		win_close = (fill_nxt >= bcdc_pkg::win_len(rate_q));

		gain_q15 = (|acc_q[ACC_W-1:39]) ? {bcdc_pkg::CLIP_W{1'b1}} : acc_q[38:24];
		gain_mag = (gain_q15 > clip_q) ? clip_q : gain_q15;
		gain_out = neg_q ? (~{1'b0, gain_mag} + 1'b1) : {1'b0, gain_mag};

		trial    = {rem_q, div_q[bcdc_pkg::DIV_W-1]};
		trial_ge = (trial >= {1'b0, dvs_q});

		avg_mag = (div_q > bcdc_pkg::DIV_W'(clip_q)) ? clip_q : div_q[bcdc_pkg::CLIP_W-1:0];
		avg_out = neg_q ? (~{1'b0, avg_mag} + 1'b1) : {1'b0, avg_mag};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			dist_q       <= 1'b0;
			crush_q      <= '0;
			rate_q       <= '0;
			gain_q       <= bcdc_pkg::GAIN_RESET;
			clip_q       <= bcdc_pkg::CLIP_RESET;
			sum_q        <= '0;
			fill_q       <= '0;
			op_q         <= '0;
			acc_q        <= '0;
			mcnt_q       <= '0;
			neg_q        <= 1'b0;
			div_q        <= '0;
			rem_q        <= '0;
			dvs_q        <= '0;
			dcnt_q       <= '0;
			left_q       <= '0;
			out_valid_q  <= 1'b0;
			out_sample_q <= '0;
			out_last_q   <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					bcdc_pkg::REG_DISTORTION_ON: dist_q  <= cfg_wdata[0];
					bcdc_pkg::REG_CRUSH_BITS:    crush_q <= cfg_wdata[bcdc_pkg::CRUSH_W-1:0];
					bcdc_pkg::REG_RATE_CODE:     rate_q  <= cfg_wdata[bcdc_pkg::RATE_W-1:0];
					bcdc_pkg::REG_OUT_GAIN:      gain_q  <= cfg_wdata[bcdc_pkg::GAIN_W-1:0];
					bcdc_pkg::REG_CLIP_LEVEL:    clip_q  <= cfg_wdata[bcdc_pkg::CLIP_W-1:0];
					default: ;
				endcase
			end

			case (state_q)
				S_IDLE: begin
					if (in_xfer) begin
						op_q    <= OP_W'(dist_q ? in_crushed : in_mag);
						neg_q   <= in_neg;
						acc_q   <= '0;
						mcnt_q  <= MC_W'(NCH - 1);
						state_q <= S_MUL;
					end
				end
				S_MUL: begin
					acc_q <= (acc_q << bcdc_pkg::CHUNK_W) + ACC_W'(pp);
					op_q  <= op_q << bcdc_pkg::CHUNK_W;
					if (mcnt_q == '0) begin
						state_q <= S_ACC;
					end else begin
						mcnt_q <= mcnt_q - 1'b1;
					end
				end
				S_ACC: begin
					if (!dist_q) begin
						out_sample_q <= $signed(gain_out);
						out_last_q   <= 1'b1;
						out_valid_q  <= 1'b1;
						left_q       <= bcdc_pkg::FILL_W'(1);
						state_q      <= S_EMIT;
					end else if (win_close) begin
						div_q   <= sum_mag[bcdc_pkg::SUM_W-2:16];
						neg_q   <= sum_sat[bcdc_pkg::SUM_W-1];
						rem_q   <= '0;
						dvs_q   <= fill_nxt;
						left_q  <= fill_nxt;
						dcnt_q  <= DC_W'(bcdc_pkg::DIV_W - 1);
						sum_q   <= '0;
						fill_q  <= '0;
						state_q <= S_DIV;
					end else begin
						sum_q   <= sum_sat;
						fill_q  <= fill_nxt;
						state_q <= S_IDLE;
					end
				end
				S_DIV: begin
					rem_q <= trial_ge ? (trial[bcdc_pkg::FILL_W-1:0] - dvs_q)
					                  : trial[bcdc_pkg::FILL_W-1:0];
					div_q <= {div_q[bcdc_pkg::DIV_W-2:0], trial_ge};
					if (dcnt_q == '0) begin
						state_q <= S_EMIT;
					end else begin
						dcnt_q <= dcnt_q - 1'b1;
					end
				end
				S_EMIT: begin
					if (!out_valid_q) begin
						out_sample_q <= $signed(avg_out);
						out_last_q   <= (left_q == bcdc_pkg::FILL_W'(1));
						out_valid_q  <= 1'b1;
					end else if (out_xfer) begin
						if (left_q == bcdc_pkg::FILL_W'(1)) begin
							out_valid_q <= 1'b0;
							state_q     <= S_IDLE;
						end else begin
							left_q     <= left_q - 1'b1;
							out_last_q <= (left_q == bcdc_pkg::FILL_W'(2));
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule
